### hdl/rurm_pkg.sv
// ---------------------------------------------------------------------------
// rurm_pkg: shared types and constants for the rectangle union raster
// Field widths, the stored rectangle record and parameter defaults.
// ---------------------------------------------------------------------------
package rurm_pkg;

  localparam int COORD_BITS    = 12;              // rectangle coordinates
  localparam int POS_BITS      = COORD_BITS + 1;  // pixel positions, box extents
  localparam int PV_BITS       = 8;               // pixel value
  localparam int QUO_BITS      = PV_BITS;         // shade quotient never exceeds 255
  localparam int CNT_OUT_BITS  = 7;               // rect_count field
  localparam int DEF_MAX_RECTS = 64;

  // One stored rectangle.
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } rect_t;

endpackage

### hdl/rect_union_mask_raster_core.sv
// ---------------------------------------------------------------------------
// rect_union_mask_raster_core: rectangle union mask raster
// Stores rectangles, tracks their bounding box and answers pixel queries.
// ---------------------------------------------------------------------------
//
//   Channel | Direction | Handshake            | Contents
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid / in_stall  | func, rect_*, pixel_col/row
//   out     | output    | out_valid / out_stall| pixel_value, image_*, count,
//           |           |                      | status
//   cfg     | input     | cfg_wr_en            | cfg_wr_data (debug_mode)
//
// A clear, an add, an unused code or a read outside the image passes from
// S_IDLE through S_DONE into the output register. A read inside the image
// scans the n stored rectangles one memory read per cycle, and in debug mode
// a covered pixel then goes through the shade divider before S_DONE.
// Reset (synchronous) empties the store and clears debug_mode; the memory
// contents are left as they are, since only entries below the count are read.
// The block stalls its input while an item is in progress, and a finished
// result waits in the output register while out_stall is high.
// ---------------------------------------------------------------------------
module rect_union_mask_raster_core #(
  parameter int MAX_RECTS = rurm_pkg::DEF_MAX_RECTS
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          func,
  input  logic [rurm_pkg::COORD_BITS-1:0]     rect_x,
  input  logic [rurm_pkg::COORD_BITS-1:0]     rect_y,
  input  logic [rurm_pkg::COORD_BITS-1:0]     rect_width,
  input  logic [rurm_pkg::COORD_BITS-1:0]     rect_height,
  input  logic [rurm_pkg::POS_BITS-1:0]       pixel_col,
  input  logic [rurm_pkg::POS_BITS-1:0]       pixel_row,
  // result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rurm_pkg::PV_BITS-1:0]        pixel_value,
  output logic [rurm_pkg::POS_BITS-1:0]       image_width,
  output logic [rurm_pkg::POS_BITS-1:0]       image_height,
  output logic [rurm_pkg::CNT_OUT_BITS-1:0]   rect_count,
  output logic [1:0]                          status
);
  import rurm_pkg::*;

  localparam int CW = $clog2(MAX_RECTS + 1);
  localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int NW = CW + QUO_BITS;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam logic [PV_BITS-1:0] FULL_VALUE = '1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DIV, S_DONE} state_t;

  state_t                state;
  logic                  debug_mode;
  logic [CW-1:0]         count;
  logic [COORD_BITS-1:0] box_min_x;
  logic [COORD_BITS-1:0] box_min_y;
  logic [POS_BITS-1:0]   box_max_x;
  logic [POS_BITS-1:0]   box_max_y;

  // Item in progress.
  logic [POS_BITS-1:0]   px;
  logic [POS_BITS-1:0]   py;
  logic [PV_BITS-1:0]    res_pv;
  logic [1:0]            res_st;

  // Scan sequencer.
  logic [CW-1:0]         scan_idx;
  logic                  rd_vld;
  logic [AW-1:0]         rd_idx;
  logic                  hit;
  logic [AW-1:0]         last;

  // Memory and divider connections.
  logic                  wr_en;
  rect_t                 wr_data;
  rect_t                 rd_data;
  logic                  div_start;
  logic                  div_done;
  logic [QUO_BITS-1:0]   div_quo;
  logic [CW-1:0]         last_p1;
  logic [NW-1:0]         div_num;

  logic                  accept;
  logic                  full;
  logic [POS_BITS-1:0]   ext_x;
  logic [POS_BITS-1:0]   ext_y;
  logic [POS_BITS-1:0]   img_w;
  logic [POS_BITS-1:0]   img_h;
  logic                  covers;
  logic                  scan_end;
  logic                  out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign full     = (count >= CW'(MAX_RECTS));

  assign ext_x = POS_BITS'(rect_x) + POS_BITS'(rect_width);
  assign ext_y = POS_BITS'(rect_y) + POS_BITS'(rect_height);

  // The box is reported as empty whenever nothing is stored.
  assign img_w = (count != '0) ? (box_max_x - POS_BITS'(box_min_x)) : '0;
  assign img_h = (count != '0) ? (box_max_y - POS_BITS'(box_min_y)) : '0;

  assign wr_en   = accept && (func == FUNC_ADD) && !full;
  assign wr_data = '{x: rect_x, y: rect_y, w: rect_width, h: rect_height};

  rurm_store #(
    .DEPTH (MAX_RECTS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (scan_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // Coverage test of the rectangle read back in the previous cycle.
  assign covers = (px >= POS_BITS'(rd_data.x)) &&
                  (px <  POS_BITS'(rd_data.x) + POS_BITS'(rd_data.w)) &&
                  (py >= POS_BITS'(rd_data.y)) &&
                  (py <  POS_BITS'(rd_data.y) + POS_BITS'(rd_data.h));

  // All reads issued and the last one checked.
  assign scan_end = (scan_idx == count) && !rd_vld;

  // Shade numerator 255 * (last + 1), formed as a shift and a subtract.
  assign last_p1   = CW'(last) + 1'b1;
  assign div_num   = (NW'(last_p1) << QUO_BITS) - NW'(last_p1);
  assign div_start = (state == S_SCAN) && scan_end && hit && debug_mode;

  rurm_div #(
    .CNT_BITS (CW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (count),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      debug_mode <= 1'b0;
      count      <= '0;
      box_min_x  <= '0;
      box_min_y  <= '0;
      box_max_x  <= '0;
      box_max_y  <= '0;
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        debug_mode <= cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            res_pv <= '0;
            res_st <= ST_OK;
            state  <= S_DONE;
            case (func)
              FUNC_CLEAR: begin
                count     <= '0;
                box_min_x <= '0;
                box_min_y <= '0;
                box_max_x <= '0;
                box_max_y <= '0;
              end
              FUNC_ADD: begin
                if (full) begin
                  res_st <= ST_FULL;
                end else begin
                  // The first rectangle sets the box outright.
                  if (count == '0 || rect_x < box_min_x) box_min_x <= rect_x;
                  if (count == '0 || rect_y < box_min_y) box_min_y <= rect_y;
                  if (count == '0 || ext_x > box_max_x)  box_max_x <= ext_x;
                  if (count == '0 || ext_y > box_max_y)  box_max_y <= ext_y;
                  count <= count + 1'b1;
                end
              end
              FUNC_READ: begin
                if (pixel_col >= img_w || pixel_row >= img_h) begin
                  res_st <= ST_OUTSIDE;
                end else begin
                  px       <= POS_BITS'(box_min_x) + pixel_col;
                  py       <= POS_BITS'(box_min_y) + pixel_row;
                  scan_idx <= '0;
                  rd_vld   <= 1'b0;
                  hit      <= 1'b0;
                  state    <= S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_SCAN: begin
          if (scan_idx != count) begin
            scan_idx <= scan_idx + 1'b1;
            rd_idx   <= scan_idx[AW-1:0];
            rd_vld   <= 1'b1;
          end else begin
            rd_vld <= 1'b0;
          end
          // Later rectangles override earlier ones, so the last hit wins.
          if (rd_vld && covers) begin
            hit  <= 1'b1;
            last <= rd_idx;
          end
          if (scan_end) begin
            if (hit && debug_mode) begin
              state <= S_DIV;
            end else begin
              res_pv <= hit ? FULL_VALUE : '0;
              state  <= S_DONE;
            end
          end
        end

        S_DIV: begin
          if (div_done) begin
            res_pv <= div_quo;
            state  <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            pixel_value  <= res_pv;
            image_width  <= img_w;
            image_height <= img_h;
            rect_count   <= CNT_OUT_BITS'(count);
            status       <= res_st;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/rurm_store.sv
// ---------------------------------------------------------------------------
// rurm_store: rectangle memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module rurm_store #(
  parameter int DEPTH = rurm_pkg::DEF_MAX_RECTS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  rurm_pkg::rect_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output rurm_pkg::rect_t rd_data
);
  import rurm_pkg::*;

  rect_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/rurm_div.sv
// ---------------------------------------------------------------------------
// rurm_div: iterative shade divider
// Restoring division giving one quotient bit per cycle, QUO_BITS bits in all.
// ---------------------------------------------------------------------------
module rurm_div #(
  parameter int CNT_BITS = 7
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [CNT_BITS+rurm_pkg::QUO_BITS-1:0] num,
  input  logic [CNT_BITS-1:0]                den,
  output logic                               done,
  output logic [rurm_pkg::QUO_BITS-1:0]      quo
);
  import rurm_pkg::*;

  localparam int NW = CNT_BITS + QUO_BITS;
  localparam int SW = $clog2(QUO_BITS);

  logic [NW-1:0] rem;
  logic [NW-1:0] dsh;
  logic [SW-1:0] step;
  logic          running;
  logic          ge;

  // The quotient is known to fit in QUO_BITS bits, so the divisor starts
  // shifted up by QUO_BITS-1 places.
  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        rem     <= num;
        dsh     <= NW'(den) << (QUO_BITS - 1);
        step    <= '0;
      end else if (running) begin
        if (ge) begin
          rem <= rem - dsh;
        end
        quo  <= {quo[QUO_BITS-2:0], ge};
        dsh  <= dsh >> 1;
        step <= step + 1'b1;
        if (step == SW'(QUO_BITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

### sim/rect_union_mask_raster_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rect_union_mask_raster_core_tb: self-checking bench for the raster core
// Sends clears, rectangle adds, pixel reads and unused codes through the
// valid/stall channel, predicts result items from its own copy of the store
// and box or takes them as typed in, and compares each result field by field.
// ----------------------------------------------------------------------------
module rect_union_mask_raster_core_tb;
  import rurm_pkg::*;

  // Operation codes carried in func.
  localparam logic [1:0] FN_CLEAR = 2'd0;
  localparam logic [1:0] FN_ADD   = 2'd1;
  localparam logic [1:0] FN_READ  = 2'd2;
  localparam logic [1:0] FN_SPARE = 2'd3;

  // Status codes reported with every result item.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam int SHELF_DEPTH     = DEF_MAX_RECTS;
  localparam int FULL_SHADE      = 255;
  localparam int RANDOM_ITEMS    = 800;
  localparam int RANDOM_PHASES   = 6;
  localparam int HOLD_OFF_CYCLES = 600;
  // Slowest item: a full scan of the store plus the shade divider, with margin.
  localparam int SETTLE_CYCLES   = 120;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int MAX_REPORTS     = 10;
  localparam int RUN_LIMIT_NS    = 2000000;

  // One input item, field for field as it appears on the ports.
  typedef struct packed {
    logic [1:0]            func;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
    logic [POS_BITS-1:0]   col;
    logic [POS_BITS-1:0]   row;
  } raster_item_t;

  // One result item.
  typedef struct packed {
    logic [PV_BITS-1:0]      value;
    logic [POS_BITS-1:0]     width;
    logic [POS_BITS-1:0]     height;
    logic [CNT_OUT_BITS-1:0] count;
    logic [1:0]              status;
  } raster_result_t;

  // A row of the directed table is either a register write or an item, and an
  // item may carry a result typed in by hand instead of the predicted one.
  typedef struct {
    bit             is_cfg;
    bit             cfg_val;
    raster_item_t   item;
    bit             typed;
    raster_result_t known;
  } plan_row_t;

  logic                    clk;
  logic                    rst         = 1'b1;
  logic                    cfg_wr_en   = 1'b0;
  logic                    cfg_wr_data = 1'b0;
  logic                    in_valid    = 1'b0;
  logic                    in_stall;
  logic [1:0]              func        = FN_CLEAR;
  logic [COORD_BITS-1:0]   rect_x      = '0;
  logic [COORD_BITS-1:0]   rect_y      = '0;
  logic [COORD_BITS-1:0]   rect_width  = '0;
  logic [COORD_BITS-1:0]   rect_height = '0;
  logic [POS_BITS-1:0]     pixel_col   = '0;
  logic [POS_BITS-1:0]     pixel_row   = '0;
  logic                    out_valid;
  logic                    out_stall   = 1'b0;
  logic [PV_BITS-1:0]      pixel_value;
  logic [POS_BITS-1:0]     image_width;
  logic [POS_BITS-1:0]     image_height;
  logic [CNT_OUT_BITS-1:0] rect_count;
  logic [1:0]              status;

  // Shadow of the block's state: the stored rectangles, their bounding box
  // and the shading register.
  rect_t                 shelf [SHELF_DEPTH];
  int                    shelf_count = 0;
  logic [COORD_BITS-1:0] lo_x = '0;
  logic [COORD_BITS-1:0] lo_y = '0;
  logic [POS_BITS-1:0]   hi_x = '0;
  logic [POS_BITS-1:0]   hi_y = '0;
  bit                    shade_mode = 1'b0;

  raster_result_t raster_answers [$];
  plan_row_t      directed_rows [$];
  int             fault_count   = 0;
  int             items_sent    = 0;
  int             burst_left    = 0;
  bit             hold_request  = 1'b0;

  rect_union_mask_raster_core uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .rect_x       (rect_x),
    .rect_y       (rect_y),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .pixel_col    (pixel_col),
    .pixel_row    (pixel_row),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_value  (pixel_value),
    .image_width  (image_width),
    .image_height (image_height),
    .rect_count   (rect_count),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The run is cut short here if the block stops answering.
  initial begin
    #(RUN_LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  // Size of the bounding box; an empty store is reported as a 0 by 0 image.
  function automatic logic [POS_BITS-1:0] span_x();
    return (shelf_count != 0) ? hi_x - lo_x : '0;
  endfunction

  function automatic logic [POS_BITS-1:0] span_y();
    return (shelf_count != 0) ? hi_y - lo_y : '0;
  endfunction

  // Applies one accepted item to the shadow state and returns the result item
  // that the block must produce for it.
  function automatic raster_result_t raster_apply(raster_item_t it);
    raster_result_t      res;
    logic [POS_BITS-1:0] end_x;
    logic [POS_BITS-1:0] end_y;
    int                  px;
    int                  py;
    int                  top_hit;
    res = '0;
    case (it.func)
      FN_CLEAR: begin
        shelf_count = 0;
        lo_x = '0;
        lo_y = '0;
        hi_x = '0;
        hi_y = '0;
      end
      FN_ADD: begin
        if (shelf_count >= SHELF_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          end_x = POS_BITS'(it.x) + POS_BITS'(it.w);
          end_y = POS_BITS'(it.y) + POS_BITS'(it.h);
          shelf[shelf_count] = '{x: it.x, y: it.y, w: it.w, h: it.h};
          // The first rectangle defines the box outright; later ones widen it.
          if (shelf_count == 0) begin
            lo_x = it.x;
            lo_y = it.y;
            hi_x = end_x;
            hi_y = end_y;
          end else begin
            if (it.x < lo_x) lo_x = it.x;
            if (it.y < lo_y) lo_y = it.y;
            if (end_x > hi_x) hi_x = end_x;
            if (end_y > hi_y) hi_y = end_y;
          end
          shelf_count++;
        end
      end
      FN_READ: begin
        if (it.col >= span_x() || it.row >= span_y()) begin
          res.status = ST_OUTSIDE;
        end else begin
          px = int'(lo_x) + int'(it.col);
          py = int'(lo_y) + int'(it.row);
          top_hit = -1;
          for (int k = 0; k < shelf_count; k++) begin
            if (px >= int'(shelf[k].x) && px < int'(shelf[k].x) + int'(shelf[k].w) &&
                py >= int'(shelf[k].y) && py < int'(shelf[k].y) + int'(shelf[k].h))
              top_hit = k;
          end
          // In shading mode the last covering rectangle picks the grey level.
          if (top_hit >= 0)
            res.value = shade_mode ? PV_BITS'((FULL_SHADE * (top_hit + 1)) / shelf_count)
                                   : PV_BITS'(FULL_SHADE);
        end
      end
      default: ;
    endcase
    res.width  = span_x();
    res.height = span_y();
    res.count  = CNT_OUT_BITS'(shelf_count);
    return res;
  endfunction

  function automatic void plan_cfg(bit v);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg  = 1'b1;
    r.cfg_val = v;
    directed_rows.push_back(r);
  endfunction

  function automatic void plan(logic [1:0] f, int x, int y, int w, int h, int col, int row,
                               bit typed, int pv, int iw, int ih, int cnt, logic [1:0] st);
    plan_row_t r;
    r = '{default: '0};
    r.item  = '{func: f, x: COORD_BITS'(x), y: COORD_BITS'(y), w: COORD_BITS'(w),
                h: COORD_BITS'(h), col: POS_BITS'(col), row: POS_BITS'(row)};
    r.typed = typed;
    r.known = '{value: PV_BITS'(pv), width: POS_BITS'(iw), height: POS_BITS'(ih),
                count: CNT_OUT_BITS'(cnt), status: st};
    directed_rows.push_back(r);
  endfunction

  // Presents one item, holds it until the block takes it, then records the
  // result it must cause. The sender works in bursts with random gaps.
  task automatic offer(input raster_item_t it, input bit typed, input raster_result_t known);
    raster_result_t predicted;
    func        <= it.func;
    rect_x      <= it.x;
    rect_y      <= it.y;
    rect_width  <= it.w;
    rect_height <= it.h;
    pixel_col   <= it.col;
    pixel_row   <= it.row;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = raster_apply(it);
    raster_answers.push_back(typed ? known : predicted);
    if (it.func != FN_SPARE) items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // Waits until every result item has come back, so that the block is idle,
  // and then writes the shading register.
  task automatic settle_and_set(input bit v);
    in_valid <= 1'b0;
    while (raster_answers.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    shade_mode = v;
  endtask

  // A rectangle near a shared base point most of the time, so that rectangles
  // overlap and reads find covered pixels; now and then one of zero size or one
  // anywhere in the coordinate space.
  function automatic raster_item_t new_rect(int base_x, int base_y);
    raster_item_t it;
    int           pick;
    it      = '0;
    it.func = FN_ADD;
    it.col  = POS_BITS'($urandom);
    it.row  = POS_BITS'($urandom);
    pick    = $urandom_range(0, 9);
    if (pick < 7) begin
      it.x = COORD_BITS'(base_x + $urandom_range(0, 63));
      it.y = COORD_BITS'(base_y + $urandom_range(0, 63));
      it.w = COORD_BITS'($urandom_range(1, 48));
      it.h = COORD_BITS'($urandom_range(1, 48));
    end else if (pick == 7) begin
      it.x = COORD_BITS'($urandom);
      it.y = COORD_BITS'($urandom);
      it.w = ($urandom_range(0, 1) != 0) ? '0 : COORD_BITS'($urandom);
      it.h = (it.w != 0) ? '0 : COORD_BITS'($urandom);
    end else begin
      it.x = COORD_BITS'($urandom);
      it.y = COORD_BITS'($urandom);
      it.w = COORD_BITS'($urandom);
      it.h = COORD_BITS'($urandom);
    end
    return it;
  endfunction

  // A pixel read: mostly inside a stored rectangle or inside the box, with some
  // on the box edge and some anywhere in the position range.
  function automatic raster_item_t new_read();
    raster_item_t        it;
    logic [POS_BITS-1:0] iw;
    logic [POS_BITS-1:0] ih;
    int                  pick;
    int                  k;
    it      = '0;
    it.func = FN_READ;
    it.x    = COORD_BITS'($urandom);
    it.y    = COORD_BITS'($urandom);
    it.w    = COORD_BITS'($urandom);
    it.h    = COORD_BITS'($urandom);
    it.col  = POS_BITS'($urandom);
    it.row  = POS_BITS'($urandom);
    iw      = span_x();
    ih      = span_y();
    pick    = $urandom_range(0, 11);
    k       = (shelf_count > 0) ? $urandom_range(0, shelf_count - 1) : 0;
    if (pick < 6 && shelf_count > 0 && shelf[k].w != 0 && shelf[k].h != 0) begin
      it.col = POS_BITS'(int'(shelf[k].x) + $urandom_range(0, int'(shelf[k].w) - 1)
                        - int'(lo_x));
      it.row = POS_BITS'(int'(shelf[k].y) + $urandom_range(0, int'(shelf[k].h) - 1)
                        - int'(lo_y));
    end else if (pick < 9 && iw != 0 && ih != 0) begin
      it.col = POS_BITS'($urandom_range(0, int'(iw) - 1));
      it.row = POS_BITS'($urandom_range(0, int'(ih) - 1));
    end else if (pick == 9) begin
      it.col = iw;
      it.row = POS_BITS'($urandom_range(0, int'(ih)));
    end
    return it;
  endfunction

  // One sequence of items: usually a clear, a batch of adds and a run of reads.
  // A filling sequence adds past the capacity of the store. A small share of
  // sequences are single items with any code and any field values.
  task automatic run_sequence(input bit fill);
    raster_item_t it;
    int           roll;
    int           adds;
    int           base_x;
    int           base_y;
    roll = $urandom_range(0, 99);
    if (!fill && roll < 10) begin
      it = '{func: 2'($urandom), x: COORD_BITS'($urandom), y: COORD_BITS'($urandom),
             w: COORD_BITS'($urandom), h: COORD_BITS'($urandom),
             col: POS_BITS'($urandom), row: POS_BITS'($urandom)};
      offer(it, 1'b0, '0);
      return;
    end
    if (fill || roll < 70) begin
      it      = new_read();
      it.func = FN_CLEAR;
      offer(it, 1'b0, '0);
    end
    if (fill)
      adds = SHELF_DEPTH + $urandom_range(1, 4);
    else if (roll < 78)
      adds = $urandom_range(9, 24);
    else
      adds = $urandom_range(1, 6);
    base_x = $urandom_range(0, 4095);
    base_y = $urandom_range(0, 4095);
    repeat (adds) offer(new_rect(base_x, base_y), 1'b0, '0);
    repeat ($urandom_range(3, 12)) offer(new_read(), 1'b0, '0);
  endtask

  task automatic log_fault(input string what, input raster_result_t want,
                           input raster_result_t got);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("%0t: %s: expected value=%0d width=%0d height=%0d count=%0d status=%0d,",
               $time, what, want.value, want.width, want.height, want.count, want.status,
               " got value=%0d width=%0d height=%0d count=%0d status=%0d",
               got.value, got.width, got.height, got.count, got.status);
  endtask

  // Result side: every accepted result item is matched against the oldest
  // outstanding one.
  initial begin
    raster_result_t got;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got = '{value: pixel_value, width: image_width, height: image_height,
                count: rect_count, status: status};
        if (raster_answers.size() == 0)
          log_fault("result item with none outstanding", '0, got);
        else if (raster_answers[0] != got)
          log_fault("result item mismatch", raster_answers.pop_front(), got);
        else
          void'(raster_answers.pop_front());
      end
    end
  end

  // Receiver: switches its stalling habit at random points between no stalls,
  // light random stalls, a regular pattern and heavy stalls. Once asked, it
  // holds off for a long stretch so that the block backs up to its input.
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int beat;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    beat      = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_OFF_CYCLES - 1;
        out_stall   <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(40, 300);
        end
        mode_left--;
        beat++;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 99) < 30);
          2:       out_stall <= ((beat % 7) < 3);
          default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  // Main sequence: reset, the directed table, then random phases with the
  // shading register alternating between them.
  initial begin
    int waited;
    // Reads on an empty store fall outside the 0 by 0 image, and the unused
    // code changes nothing even with every field at its maximum.
    plan(FN_READ,  0, 0, 0, 0, 0, 0,              1, 0, 0, 0, 0, ST_OUTSIDE);
    plan(FN_SPARE, 4095, 4095, 4095, 4095, 8191, 8191, 1, 0, 0, 0, 0, ST_OK);
    // The first add sets the box to exactly that rectangle.
    plan(FN_ADD,   10, 20, 30, 40, 0, 0,          1, 0, 30, 40, 1, ST_OK);
    plan(FN_READ,  0, 0, 0, 0, 0, 0,              1, 255, 30, 40, 1, ST_OK);
    plan(FN_READ,  0, 0, 0, 0, 29, 39,            1, 255, 30, 40, 1, ST_OK);
    plan(FN_READ,  0, 0, 0, 0, 30, 0,             1, 0, 30, 40, 1, ST_OUTSIDE);
    plan(FN_READ,  0, 0, 0, 0, 0, 40,             1, 0, 30, 40, 1, ST_OUTSIDE);
    // A rectangle of zero size widens the box but covers nothing.
    plan(FN_ADD,   0, 0, 0, 0, 0, 0,              1, 0, 40, 60, 2, ST_OK);
    plan(FN_READ,  0, 0, 0, 0, 0, 0,              1, 0, 40, 60, 2, ST_OK);
    plan_cfg(1'b1);
    plan(FN_READ,  0, 0, 0, 0, 10, 20,            1, 127, 40, 60, 2, ST_OK);
    // Largest rectangle at the far corner gives the widest possible box.
    plan(FN_ADD,   4095, 4095, 4095, 4095, 0, 0,  1, 0, 8190, 8190, 3, ST_OK);
    plan(FN_READ,  0, 0, 0, 0, 8189, 8189,        1, 255, 8190, 8190, 3, ST_OK);
    plan(FN_READ,  0, 0, 0, 0, 8191, 8191,        1, 0, 8190, 8190, 3, ST_OUTSIDE);
    plan(FN_READ,  0, 0, 0, 0, 4095, 4095,        0, 0, 0, 0, 0, ST_OK);
    plan(FN_ADD,   0, 0, 4095, 4095, 0, 0,        0, 0, 0, 0, 0, ST_OK);
    plan(FN_READ,  0, 0, 0, 0, 20, 30,            0, 0, 0, 0, 0, ST_OK);
    plan(FN_ADD,   5, 5, 1, 1, 0, 0,              0, 0, 0, 0, 0, ST_OK);
    plan(FN_READ,  0, 0, 0, 0, 4, 4,              0, 0, 0, 0, 0, ST_OK);
    plan(FN_READ,  0, 0, 0, 0, 5, 5,              0, 0, 0, 0, 0, ST_OK);
    plan_cfg(1'b0);
    plan(FN_READ,  0, 0, 0, 0, 4, 4,              0, 0, 0, 0, 0, ST_OK);
    // A clear empties the store and the box.
    plan(FN_CLEAR, 0, 0, 0, 0, 0, 0,              1, 0, 0, 0, 0, ST_OK);
    plan(FN_READ,  0, 0, 0, 0, 0, 0,              1, 0, 0, 0, 0, ST_OUTSIDE);
    // A zero-width first rectangle leaves no readable column.
    plan(FN_ADD,   4095, 0, 0, 4095, 0, 0,        1, 0, 0, 4095, 1, ST_OK);
    plan(FN_READ,  0, 0, 0, 0, 0, 0,              1, 0, 0, 4095, 1, ST_OUTSIDE);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        settle_and_set(directed_rows[i].cfg_val);
      else
        offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].known);
    end

    items_sent = 0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle_and_set((p % 2) == 0);
      if (p == 0) hold_request = 1'b1;
      // Two phases open by filling the store beyond its capacity.
      if (p == 2 || p == 4) run_sequence(1'b1);
      while (items_sent < ((p + 1) * RANDOM_ITEMS) / RANDOM_PHASES)
        run_sequence(1'b0);
    end

    in_valid <= 1'b0;
    waited = 0;
    while (raster_answers.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (raster_answers.size() != 0)
      $display("%0d result items never arrived", raster_answers.size());
    if (fault_count == 0 && raster_answers.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### filelist.f
hdl/rurm_pkg.sv
hdl/rurm_store.sv
hdl/rurm_div.sv
hdl/rect_union_mask_raster_core.sv
sim/rect_union_mask_raster_core_tb.sv
